[rtl/pps_pkg.sv]
// Shared types and constants of the preemptive priority scheduler.
// Used by the channel interfaces, the slot cell and the top level; no dependencies.

package pps_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int TIME_BITS_DEF = 16;
	localparam int PRIO_BITS_DEF = 8;

	localparam int ID_W      = 8;
	localparam int FTIME_W   = 16;
	localparam int FPRIO_W   = 8;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

[rtl/pps_item_if.sv]
// Input channel of the scheduler: valid/ready handshake with one add or tick item.
// Depends on pps_pkg for the field widths.

interface pps_item_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [pps_pkg::ID_W-1:0]   proc_id;
	logic [pps_pkg::FTIME_W-1:0] arrival_time;
	logic [pps_pkg::FTIME_W-1:0] burst_length;
	logic [pps_pkg::FPRIO_W-1:0] priority_level;

	modport source (
		output valid, mode, proc_id, arrival_time, burst_length, priority_level,
		input  ready
	);
	modport sink (
		input  valid, mode, proc_id, arrival_time, burst_length, priority_level,
		output ready
	);
endinterface

[rtl/pps_result_if.sv]
// Output channel of the scheduler: valid/ready handshake with one completion or reject.
// Depends on pps_pkg for the field widths.

interface pps_result_if;
	logic                        valid;
	logic                        ready;
	logic                        status;
	logic [pps_pkg::ID_W-1:0]    done_id;
	logic [pps_pkg::FTIME_W-1:0] completion_time;
	logic [pps_pkg::FTIME_W-1:0] turnaround;
	logic [pps_pkg::FTIME_W-1:0] waiting;

	modport source (
		output valid, status, done_id, completion_time, turnaround, waiting,
		input  ready
	);
	modport sink (
		input  valid, status, done_id, completion_time, turnaround, waiting,
		output ready
	);
endinterface

[rtl/pps_cell.sv]
// One process slot of the scheduler chain: holds the slot and registers the scan token.
// Depends on pps_pkg for the mode codes.

module pps_cell #(
	parameter int SLOTS     = pps_pkg::SLOTS_DEF,
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
	parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF,
	parameter int CELL_IDX  = 0,
	localparam int IDX_W    = $clog2(SLOTS)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [3+IDX_W+pps_pkg::ID_W+3*TIME_BITS+PRIO_BITS-1:0] tok_in,
	input  logic [TIME_BITS-1:0] now_time,
	input  logic [IDX_W:0] cmd,
	output logic [3+IDX_W+pps_pkg::ID_W+3*TIME_BITS+PRIO_BITS-1:0] tok_out
);

	typedef struct packed {
		logic                     vld;
		logic                     op;
		logic                     found;
		logic [IDX_W-1:0]         idx;
		logic [pps_pkg::ID_W-1:0] id;
		logic [TIME_BITS-1:0]     arrival;
		logic [TIME_BITS-1:0]     burst;
		logic [TIME_BITS-1:0]     remaining;
		logic [PRIO_BITS-1:0]     prio;
	} tok_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	tok_t tin, tok_d, tok_q;
	cmd_t cin;

	logic                     busy_q;
	logic [pps_pkg::ID_W-1:0] id_q;
	logic [TIME_BITS-1:0]     arrival_q;
	logic [TIME_BITS-1:0]     burst_q;
	logic [TIME_BITS-1:0]     remaining_q;
	logic [PRIO_BITS-1:0]     prio_q;

	logic take, ready, better, hit;

	assign tin     = tok_t'(tok_in);
	assign cin     = cmd_t'(cmd);
	assign tok_out = tok_q;

	assign take  = tin.vld && (tin.op == pps_pkg::MODE_ADD) && !tin.found && !busy_q;
	assign ready = busy_q && (remaining_q != '0) && (arrival_q <= now_time);
	assign better = tin.vld && (tin.op == pps_pkg::MODE_TICK) && ready &&
		(!tin.found || (prio_q > tin.prio) ||
		 ((prio_q == tin.prio) && (arrival_q < tin.arrival)));
	assign hit = cin.en && (cin.idx == IDX_W'(CELL_IDX));

	always_comb begin
		tok_d = tin;
		if (take) begin
			tok_d.found = 1'b1;
		end else if (better) begin
			tok_d.found     = 1'b1;
			tok_d.idx       = IDX_W'(CELL_IDX);
			tok_d.id        = id_q;
			tok_d.arrival   = arrival_q;
			tok_d.burst     = burst_q;
			tok_d.remaining = remaining_q;
			tok_d.prio      = prio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			if (take) begin
				busy_q <= 1'b1;
			end else if (hit && (remaining_q == TIME_BITS'(1))) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_q        <= tin.id;
			arrival_q   <= tin.arrival;
			burst_q     <= tin.burst;
			remaining_q <= tin.burst;
			prio_q      <= tin.prio;
		end else if (hit) begin
			remaining_q <= remaining_q - TIME_BITS'(1);
		end
	end

endmodule

[rtl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: control, time counter and result register.
// Depends on pps_pkg, pps_item_if, pps_result_if and a chain of pps_cell slots.
//
// Usage: items arrive on the item channel, results leave on the result channel; both
// are valid/ready channels and a transaction completes when valid and ready are high.
// An add item (mode 0) stores a process in the lowest free slot; if every slot is busy
// it yields one result with status 1. A tick item (mode 1) runs one time unit for the
// ready process of highest priority and yields a result with status 0 when that
// process finishes. An add with zero burst is absorbed and yields nothing.
// Each item sends one token down the row of SLOTS cells, one cell per cycle; the token
// leaving the last cell is captured, the finish step commits it and ready is high again
// once the block is back in its idle step. A result, when there is one, is loaded into
// the output register at the commit and becomes valid from that register. An add with
// zero burst is taken in the idle step and sends no token.
// Results wait in an output register, so a new item is taken while a result is still
// pending; if the receiver stalls and a second result is due, the block holds in its
// last step until the register is free.
// Reset clears time to zero, marks every slot free and empties the output register.

module preemptive_priority_scheduler #(
	parameter int SLOTS     = pps_pkg::SLOTS_DEF,
	parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
	parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	pps_item_if.sink     item,
	pps_result_if.source result
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int TOK_W = 3 + IDX_W + pps_pkg::ID_W + 3 * TIME_BITS + PRIO_BITS;

	typedef struct packed {
		logic                     vld;
		logic                     op;
		logic                     found;
		logic [IDX_W-1:0]         idx;
		logic [pps_pkg::ID_W-1:0] id;
		logic [TIME_BITS-1:0]     arrival;
		logic [TIME_BITS-1:0]     burst;
		logic [TIME_BITS-1:0]     remaining;
		logic [PRIO_BITS-1:0]     prio;
	} tok_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	pps_pkg::state_t state_q, state_d;

	logic [TOK_W-1:0] tok_link [0:SLOTS];
	logic [SLOTS-1:0] chain_vld;
	tok_t tok_head, tail;
	cmd_t cmd;

	logic [TIME_BITS-1:0] now_q;
	tok_t                 fin_q;
	logic [TIME_BITS-1:0] fin_ct_q;
	logic [TIME_BITS-1:0] fin_ta_q;

	logic [TIME_BITS+pps_pkg::FTIME_W-1:0] arr_ext, burst_ext;
	logic [PRIO_BITS+pps_pkg::FPRIO_W-1:0] prio_ext;
	logic [TIME_BITS-1:0] arr_in, burst_in;
	logic [PRIO_BITS-1:0] prio_in;

	logic item_ready, inject, capture, commit, need_res;
	logic is_reject;
	logic [TIME_BITS-1:0] ct_res, ta_res, wt_res;
	logic [TIME_BITS+pps_pkg::FTIME_W-1:0] ct_ext, ta_ext, wt_ext;

	logic                          out_valid_q;
	logic                          out_status_q;
	logic [pps_pkg::ID_W-1:0]      out_id_q;
	logic [pps_pkg::FTIME_W-1:0]   out_ct_q, out_ta_q, out_wt_q;

	assign arr_ext   = {{TIME_BITS{1'b0}}, item.arrival_time};
	assign burst_ext = {{TIME_BITS{1'b0}}, item.burst_length};
	assign prio_ext  = {{PRIO_BITS{1'b0}}, item.priority_level};
	assign arr_in    = arr_ext[TIME_BITS-1:0];
	assign burst_in  = burst_ext[TIME_BITS-1:0];
	assign prio_in   = prio_ext[PRIO_BITS-1:0];

	always_comb begin
		tok_head           = '0;
		tok_head.vld       = inject;
		tok_head.op        = item.mode;
		tok_head.id        = item.proc_id;
		tok_head.arrival   = arr_in;
		tok_head.burst     = burst_in;
		tok_head.remaining = burst_in;
		tok_head.prio      = prio_in;
	end

	assign tok_link[0] = tok_head;
	assign tail        = tok_t'(tok_link[SLOTS]);

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		pps_cell #(
			.SLOTS     (SLOTS),
			.TIME_BITS (TIME_BITS),
			.PRIO_BITS (PRIO_BITS),
			.CELL_IDX  (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_link[k]),
			.now_time (now_q),
			.cmd      (cmd),
			.tok_out  (tok_link[k+1])
		);
		assign chain_vld[k] = tok_link[k+1][TOK_W-1];
	end

	assign is_reject = (fin_q.op == pps_pkg::MODE_ADD) && !fin_q.found;
	assign need_res  = is_reject ||
		((fin_q.op == pps_pkg::MODE_TICK) && fin_q.found &&
		 (fin_q.remaining == TIME_BITS'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		inject     = 1'b0;
		capture    = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item.valid && ((item.mode == pps_pkg::MODE_TICK) || (burst_in != '0))) begin
					inject  = 1'b1;
					state_d = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (tail.vld) begin
					capture = 1'b1;
					state_d = pps_pkg::ST_FINISH;
				end
			end
			pps_pkg::ST_FINISH: begin
				if (!need_res || !out_valid_q || result.ready) begin
					commit  = 1'b1;
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pps_pkg::ST_IDLE;
			end
		endcase
	end

	assign item.ready = item_ready;
	assign cmd.en     = commit && (fin_q.op == pps_pkg::MODE_TICK) && fin_q.found;
	assign cmd.idx    = fin_q.idx;

	always_ff @(posedge clk) begin
		if (capture) begin
			fin_q    <= tail;
			fin_ct_q <= now_q + TIME_BITS'(1);
			fin_ta_q <= now_q + TIME_BITS'(1) - tail.arrival;
		end
	end

	assign ct_res = is_reject ? '0 : fin_ct_q;
	assign ta_res = is_reject ? '0 : fin_ta_q;
	assign wt_res = is_reject ? '0 : (fin_ta_q - fin_q.burst);
	assign ct_ext = {{pps_pkg::FTIME_W{1'b0}}, ct_res};
	assign ta_ext = {{pps_pkg::FTIME_W{1'b0}}, ta_res};
	assign wt_ext = {{pps_pkg::FTIME_W{1'b0}}, wt_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit && (fin_q.op == pps_pkg::MODE_TICK)) begin
				now_q <= now_q + TIME_BITS'(1);
			end
			if (commit && need_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && need_res) begin
			out_status_q <= is_reject ? pps_pkg::STATUS_FULL : pps_pkg::STATUS_DONE;
			out_id_q     <= fin_q.id;
			out_ct_q     <= ct_ext[pps_pkg::FTIME_W-1:0];
			out_ta_q     <= ta_ext[pps_pkg::FTIME_W-1:0];
			out_wt_q     <= wt_ext[pps_pkg::FTIME_W-1:0];
		end
	end

	assign result.valid           = out_valid_q;
	assign result.status          = out_status_q;
	assign result.done_id         = out_id_q;
	assign result.completion_time = out_ct_q;
	assign result.turnaround      = out_ta_q;
	assign result.waiting         = out_wt_q;

	// Exactly one token travels the cell row during a scan and none otherwise.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pps_pkg::ST_SCAN) |-> ($countones(chain_vld) == 1))
		else $error("scan token count is not one");

	a_empty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != pps_pkg::ST_SCAN) |-> (chain_vld == '0))
		else $error("token in cell row outside a scan");

	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (fin_q.op == pps_pkg::MODE_TICK)) |=> (now_q == $past(now_q) + TIME_BITS'(1)))
		else $error("tick did not advance time by one");

	a_load_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == pps_pkg::ST_FINISH))
		else $error("result loaded outside the finish step");

endmodule
